// ===== hw/rtl/btlv_pkg.sv =====
// Package for the BER identifier/length header encoder.
// Holds field widths, octet codes and the descriptor passed from front to back.
// No dependencies.
`default_nettype none

package btlv_pkg;

   // Port field widths
   localparam int FORM_W    = 2;
   localparam int CLASS_W   = 2;
   localparam int TAG_W     = 31;
   localparam int LEN_W     = 31;
   localparam int SIZE_W    = 32;
   localparam int CNT_W     = 3;

   // Defaults for top-level parameters
   localparam int DEF_TAG_BITS    = 31;
   localparam int DEF_LENGTH_BITS = 31;
   localparam int DEF_QUEUE_DEPTH = 2;

   // Most base-128 groups of a tag, most octets of a long-form length
   localparam int MAX_GROUPS    = 5;
   localparam int MAX_LEN_BYTES = 4;

   // Form codes
   localparam logic [FORM_W-1:0] FORM_PRIMITIVE  = 2'd0;
   localparam logic [FORM_W-1:0] FORM_INDEFINITE = 2'd2;

   // Octet codes
   localparam logic [7:0] CONSTRUCTED_BIT = 8'h20;
   localparam logic [7:0] TAG_ESCAPE      = 8'h1f;
   localparam logic [7:0] LEN_LONG_FLAG   = 8'h80;
   localparam logic [7:0] LEN_INDEFINITE  = 8'h80;
   localparam logic [7:0] SHORT_LEN_MAX   = 8'd127;
   localparam logic [7:0] SHORT_TAG_LIMIT = 8'd31;
   localparam logic [SIZE_W-1:0] EOC_OCTETS = 32'd2;

   // One classified header, ready for octet generation
   typedef struct packed {
      logic [7:0]        ident;
      logic              long_tag;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  groups;
      logic [7:0]        len_hdr;
      logic [LEN_W-1:0]  len;
      logic [CNT_W-1:0]  lbytes;
      logic [SIZE_W-1:0] size;
   } desc_type;

   // Pick base-128 group idx (0 = least significant) of a tag
   function automatic logic [6:0] tag_group(input logic [TAG_W-1:0] tag,
                                            input logic [CNT_W-1:0] idx);
      logic [6:0] grp;
      grp = '0;
      for (int k = 0; k < MAX_GROUPS; k++) begin
         if (idx == CNT_W'(k)) begin
            grp = 7'(tag >> (7 * k));
         end
      end
      return grp;
   endfunction

   // Pick octet idx (0 = least significant) of a length
   function automatic logic [7:0] len_octet(input logic [LEN_W-1:0] len,
                                            input logic [CNT_W-1:0] idx);
      logic [7:0] oct;
      oct = '0;
      for (int k = 0; k < MAX_LEN_BYTES; k++) begin
         if (idx == CNT_W'(k)) begin
            oct = 8'(len >> (8 * k));
         end
      end
      return oct;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/btlv_if.sv =====
// Channel interfaces for the BER header encoder: request and response.
// Depends on btlv_pkg for field widths.
`default_nettype none

interface btlv_req_if
   import btlv_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FORM_W-1:0]  form;
   logic [CLASS_W-1:0] tag_class;
   logic [TAG_W-1:0]   tag_number;
   logic [LEN_W-1:0]   content_length;

   modport source (output valid, form, tag_class, tag_number, content_length,
                   input ready);
   modport sink   (input valid, form, tag_class, tag_number, content_length,
                   output ready);
endinterface

interface btlv_rsp_if
   import btlv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [7:0]        out_byte;
   logic              last_byte;
   logic [SIZE_W-1:0] object_size;

   modport source (output valid, out_byte, last_byte, object_size, input ready);
   modport sink   (input valid, out_byte, last_byte, object_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ber_tlv_header_encoder.sv =====
// BER identifier/length header encoder, top level.
// The first octet of a transaction passes through the descriptor queue and then the
// response register; one octet per cycle leaves while rsp ready allows, and an item
// has 2 to 11 header octets, all from the single octet output of the back-end sequencer.
// A new request is accepted every cycle while the descriptor queue has room.
// Reset (synchronous) empties the queue, restarts the sequencer, drops rsp valid.
`default_nettype none

module ber_tlv_header_encoder
   import btlv_pkg::*;
#(
   parameter int TAG_BITS    = DEF_TAG_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   btlv_req_if.sink   req_chan,
   btlv_rsp_if.source rsp_chan
);

   logic     push;
   logic     pop;
   logic     full;
   logic     empty;
   desc_type push_desc;
   desc_type head;

   // Classify incoming transactions
   btlv_front #(
      .TAG_BITS    (TAG_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .desc       (push_desc)
   );

   // Decouple front end from sequencer
   btlv_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   // Emit header octets
   btlv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/btlv_front.sv =====
// Front end: accepts a request transaction and classifies it into a descriptor.
// Depends on btlv_pkg and btlv_req_if.
`default_nettype none

module btlv_front
   import btlv_pkg::*;
#(
   parameter int TAG_BITS    = DEF_TAG_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   btlv_req_if.sink   req_chan,
   input  logic       queue_full,
   output logic       push,
   output desc_type   desc
);

   localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 64'd1);
   localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

   logic [TAG_W-1:0] tag;
   logic [LEN_W-1:0] len;
   logic             constructed;
   logic             indefinite;
   logic             long_tag;
   logic [CNT_W-1:0] groups;
   logic [CNT_W-1:0] lbytes;
   logic [3:0]       n_octets;

   // Take a transaction whenever the queue has room
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Classify form, tag and length
   always_comb begin
      tag         = req_chan.tag_number & TAG_MASK;
      len         = req_chan.content_length & LEN_MASK;
      constructed = req_chan.form != FORM_PRIMITIVE;
      indefinite  = req_chan.form == FORM_INDEFINITE;
      long_tag    = tag >= TAG_W'(SHORT_TAG_LIMIT);

      groups = CNT_W'(1);
      for (int k = 1; k < MAX_GROUPS; k++) begin
         groups = groups + CNT_W'((tag >> (7 * k)) != '0);
      end

      lbytes = '0;
      if (!indefinite && len > LEN_W'(SHORT_LEN_MAX)) begin
         lbytes = CNT_W'(1);
         for (int k = 1; k < MAX_LEN_BYTES; k++) begin
            lbytes = lbytes + CNT_W'((len >> (8 * k)) != '0);
         end
      end

      desc.ident = {req_chan.tag_class, 6'd0} | (constructed ? CONSTRUCTED_BIT : 8'd0)
                 | (long_tag ? TAG_ESCAPE : {3'd0, tag[4:0]});
      desc.long_tag = long_tag;
      desc.tag      = tag;
      desc.groups   = groups;
      desc.len      = len;
      desc.lbytes   = lbytes;
      if (indefinite) begin
         desc.len_hdr = LEN_INDEFINITE;
      end else if (lbytes == '0) begin
         desc.len_hdr = {1'b0, len[6:0]};
      end else begin
         desc.len_hdr = LEN_LONG_FLAG | {5'd0, lbytes};
      end

      // Identifier octet, optional tag groups, length octet, then optional length octets
      n_octets  = 4'd2 + (long_tag ? {1'b0, groups} : 4'd0) + {1'b0, lbytes};
      desc.size = SIZE_W'(n_octets) + SIZE_W'(len) + (indefinite ? EOC_OCTETS : '0);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/btlv_queue.sv =====
// Short descriptor queue between the front end and the octet sequencer.
// Depends on btlv_pkg for the descriptor type.
`default_nettype none

module btlv_queue
   import btlv_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output desc_type head
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == COUNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/btlv_back.sv =====
// Back end: walks the head descriptor and emits one header octet per cycle while the response register is free.
// Depends on btlv_pkg and btlv_rsp_if.
`default_nettype none

module btlv_back
   import btlv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      empty,
   input  desc_type  head,
   output logic      pop,
   btlv_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      PH_IDENT,
      PH_TAG,
      PH_LHDR,
      PH_LEN
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              last_byte_ff;
   logic [SIZE_W-1:0] object_size_ff;

   logic              advance;
   logic              fire;
   logic [7:0]        byte_c;
   logic              last_c;
   logic [CNT_W-1:0]  idx;

   // Output register frees up when empty or taken downstream
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire    = advance && !empty;
   assign pop     = fire && last_c;
   assign idx     = cnt_ff - CNT_W'(1);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.last_byte   = last_byte_ff;
   assign rsp_chan.object_size = object_size_ff;

   // Select current octet and next phase
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      byte_c   = head.ident;
      last_c   = 1'b0;
      case (phase_ff)
         PH_IDENT: begin
            byte_c = head.ident;
            if (head.long_tag) begin
               phase_in = PH_TAG;
               cnt_in   = head.groups;
            end else begin
               phase_in = PH_LHDR;
            end
         end
         PH_TAG: begin
            byte_c = {cnt_ff != CNT_W'(1), tag_group(head.tag, idx)};
            if (cnt_ff == CNT_W'(1)) begin
               phase_in = PH_LHDR;
            end
            cnt_in = idx;
         end
         PH_LHDR: begin
            byte_c = head.len_hdr;
            if (head.lbytes == '0) begin
               last_c   = 1'b1;
               phase_in = PH_IDENT;
            end else begin
               phase_in = PH_LEN;
               cnt_in   = head.lbytes;
            end
         end
         PH_LEN: begin
            byte_c = len_octet(head.len, idx);
            if (cnt_ff == CNT_W'(1)) begin
               last_c   = 1'b1;
               phase_in = PH_IDENT;
            end
            cnt_in = idx;
         end
         default: begin
            phase_in = PH_IDENT;
         end
      endcase
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDENT;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         out_byte_ff    <= '0;
         last_byte_ff   <= 1'b0;
         object_size_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff <= fire;
         if (fire) begin
            phase_ff       <= phase_in;
            cnt_ff         <= cnt_in;
            out_byte_ff    <= byte_c;
            last_byte_ff   <= last_c;
            object_size_ff <= head.size;
         end
      end
   end

endmodule

`default_nettype wire
